// File: hdl/sbs_pkg.sv
// Shared constants, codes and types for the sorted-table binary search core.
// Used by sbs_table_ram and sorted_table_binary_search_core; no dependencies.
package sbs_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = IDX_W + 1;

   localparam logic ACT_WRITE  = 1'b0;
   localparam logic ACT_SEARCH = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_CMP
   } state_type;

   typedef struct packed {
      logic                   wr_en;
      logic [IDX_W-1:0]       wr_addr;
      logic [VALUE_WIDTH-1:0] wr_data;
      logic                   rd_en;
      logic [IDX_W-1:0]       rd_addr;
   } ram_req_type;

endpackage

// File: hdl/sbs_table_ram.sv
// Table storage: one write port and one read port with registered read data.
// Depends on sbs_pkg for depth, width and the request struct.
module sbs_table_ram (
   input  logic                           clock,
   input  sbs_pkg::ram_req_type           ram_req,
   output logic [sbs_pkg::VALUE_WIDTH-1:0] rd_data
);
   import sbs_pkg::*;

   logic [VALUE_WIDTH-1:0] mem_ff [TABLE_DEPTH];
   logic [VALUE_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem_ff[ram_req.wr_addr] <= ram_req.wr_data;
      end
      if (ram_req.rd_en) begin
         rd_data_ff <= mem_ff[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/sorted_table_binary_search_core.sv
// Top level of the sorted-table binary search core: handshakes, sequencer
// and result register. Depends on sbs_pkg and sbs_table_ram.
//
// Usage:
//   req channel: a transaction with req_action = write stores req_entry_value
//   at req_entry_index and returns nothing. A transaction with
//   req_action = search looks up req_search_key among entries
//   0 .. min(entry_count, 1024)-1 and returns one rsp transaction with
//   rsp_found and rsp_position (0 when not found).
//   csr channel: writes entry_count; always ready, write only while idle.
//   Search: each probe is a memory read cycle followed by a compare
//   cycle; when the key is absent the search ends in the probe state once
//   the range is empty. At most 11 probes for 1024 entries, after which
//   the result is registered and rsp_valid rises.
//   Throughput: writes are accepted back to back, one per cycle, while no
//   search runs and no result waits. A search occupies the block until its
//   result transfers with rsp_ready high, after which req_ready rises.
//   One transaction is in flight at a time: req_ready is low while a search
//   runs and while a result waits in the output register. A stalled receiver
//   (rsp_ready low) holds the result and blocks new requests.
//   Reset clears the sequencer, the output valid and entry_count; table
//   contents are undefined until written.
module sorted_table_binary_search_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_action,
   input  logic [sbs_pkg::IDX_W-1:0]            req_entry_index,
   input  logic signed [sbs_pkg::VALUE_WIDTH-1:0] req_entry_value,
   input  logic signed [sbs_pkg::VALUE_WIDTH-1:0] req_search_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_found,
   output logic [sbs_pkg::IDX_W-1:0]            rsp_position,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sbs_pkg::CNT_W-1:0]            csr_entry_count
);
   import sbs_pkg::*;

   state_type                     state_ff, state_in;
   logic [CNT_W-1:0]              entry_count_ff;
   logic [CNT_W-1:0]              lo_ff, lo_in;
   logic [CNT_W-1:0]              hi_ff, hi_in;
   logic [CNT_W-1:0]              mid_ff, mid_in;
   logic signed [VALUE_WIDTH-1:0] key_ff, key_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_found_ff, rsp_found_in;
   logic [IDX_W-1:0]              rsp_position_ff, rsp_position_in;

   logic                          req_accept;
   logic [CNT_W-1:0]              search_len;
   logic [CNT_W-1:0]              span;
   logic [CNT_W-1:0]              probe_mid;
   ram_req_type                   ram_req;
   logic [VALUE_WIDTH-1:0]        rd_data;
   logic signed [VALUE_WIDTH-1:0] entry;

   sbs_table_ram u_table (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;

   assign search_len = (entry_count_ff > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                              : entry_count_ff;
   assign span      = hi_ff - lo_ff - CNT_W'(1);
   assign probe_mid = lo_ff + (span >> 1);
   assign entry     = $signed(rd_data);

   always_comb begin
      state_in        = state_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      mid_in          = mid_ff;
      key_in          = key_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = req_entry_index;
      ram_req.wr_data = req_entry_value;
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = probe_mid[IDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_action == ACT_WRITE) begin
                  ram_req.wr_en = 1'b1;
               end else begin
                  key_in   = req_search_key;
                  lo_in    = '0;
                  hi_in    = search_len;
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            if (lo_ff < hi_ff) begin
               ram_req.rd_en = 1'b1;
               mid_in        = probe_mid;
               state_in      = ST_CMP;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b0;
               rsp_position_in = '0;
               state_in        = ST_IDLE;
            end
         end
         ST_CMP: begin
            if (entry < key_ff) begin
               lo_in    = mid_ff + CNT_W'(1);
               state_in = ST_PROBE;
            end else if (entry > key_ff) begin
               hi_in    = mid_ff;
               state_in = ST_PROBE;
            end else begin
               rsp_valid_in    = 1'b1;
               rsp_found_in    = 1'b1;
               rsp_position_in = mid_ff[IDX_W-1:0];
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         entry_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            entry_count_ff <= csr_entry_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff           <= lo_in;
      hi_ff           <= hi_in;
      mid_ff          <= mid_in;
      key_ff          <= key_in;
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;

   a_cmp_range_open: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (mid_ff >= lo_ff) && (mid_ff < hi_ff))
      else $error("probe outside open range");

   a_range_bounded: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (hi_ff <= CNT_W'(TABLE_DEPTH)))
      else $error("search range beyond table depth");

   a_miss_position_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_found_ff) |-> (rsp_position_ff == '0))
      else $error("nonzero position on miss");

   a_rsp_from_search: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_PROBE) || ($past(state_ff) == ST_CMP))
      else $error("result raised outside search");

   a_busy_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready && !rsp_valid_ff)
      else $error("request taken or result pending during search");

endmodule

// File: dv/tb_sorted_table_binary_search_core.sv
// Testbench for sorted_table_binary_search_core: directed and random table loads and
// key lookups, scored against an in-bench binary search over a mirror of the table.
// Depends on sbs_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_sorted_table_binary_search_core;
   import sbs_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 30;
   localparam int RSP_HOLD      = 400;
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
   localparam logic signed [VALUE_WIDTH-1:0] VALUE_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] position;
   } lookup_type;

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_action;
   logic [IDX_W-1:0]              req_entry_index;
   logic signed [VALUE_WIDTH-1:0] req_entry_value;
   logic signed [VALUE_WIDTH-1:0] req_search_key;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_found;
   logic [IDX_W-1:0]              rsp_position;
   logic                          csr_valid;
   logic                          csr_ready;
   logic [CNT_W-1:0]              csr_entry_count;

   logic signed [VALUE_WIDTH-1:0] entry_mirror [TABLE_DEPTH];
   logic [CNT_W-1:0]              count_mirror;
   lookup_type                    pending_lookups [$];
   int                            mismatch_count;
   int                            items_sent;
   int                            cycle_count;
   int                            tx_idle_pct;
   int                            rx_idle_pct;
   int                            rx_hold_left;

   sorted_table_binary_search_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_entry_index (req_entry_index),
      .req_entry_value (req_entry_value),
      .req_search_key  (req_search_key),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_entry_count (csr_entry_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic lookup_type predict_lookup(input logic signed [VALUE_WIDTH-1:0] key);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      lookup_type  res;
      res.found    = 1'b0;
      res.position = '0;
      lo = 0;
      hi = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
      while (lo < hi) begin
         mid = lo + (hi - 1 - lo) / 2;
         if (entry_mirror[mid] < key) begin
            lo = mid + 1;
         end else if (entry_mirror[mid] > key) begin
            hi = mid;
         end else begin
            res.found    = 1'b1;
            res.position = mid[IDX_W-1:0];
            return res;
         end
      end
      return res;
   endfunction

   // response scoreboard
   always @(posedge clock) begin
      lookup_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_lookups.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%0t unexpected response: found=%0b position=%0d",
                        $realtime, rsp_found, rsp_position);
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_found !== want.found || rsp_position !== want.position) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"%0t lookup mismatch: expected found=%0b position=%0d,",
                            " got found=%0b position=%0d"},
                           $realtime, want.found, want.position, rsp_found, rsp_position);
            end
         end
      end
   end

   // response side throttle
   initial begin
      forever begin
         @(negedge clock);
         if (rx_hold_left > 0) begin
            rsp_ready = 1'b0;
            rx_hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   task automatic offer_item(input logic act, input logic [IDX_W-1:0] idx,
                             input logic signed [VALUE_WIDTH-1:0] val,
                             input logic signed [VALUE_WIDTH-1:0] key);
      @(negedge clock);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid       = 1'b1;
      req_action      = act;
      req_entry_index = idx;
      req_entry_value = val;
      req_search_key  = key;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (act == ACT_WRITE)
         entry_mirror[idx] = val;
      else
         pending_lookups.push_back(predict_lookup(key));
      items_sent++;
   endtask

   task automatic write_entry(input int idx, input logic signed [VALUE_WIDTH-1:0] val);
      offer_item(ACT_WRITE, idx[IDX_W-1:0], val, $urandom);
   endtask

   task automatic lookup_key(input logic signed [VALUE_WIDTH-1:0] key);
      offer_item(ACT_SEARCH, IDX_W'($urandom_range(TABLE_DEPTH-1)), $urandom, key);
   endtask

   task automatic drain_lookups();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_entry_count(input int cnt);
      drain_lookups();
      @(negedge clock);
      csr_valid       = 1'b1;
      csr_entry_count = cnt[CNT_W-1:0];
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      count_mirror = cnt[CNT_W-1:0];
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic test_directed();
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      lookup_key(32'sd0);
      write_entry(0, VALUE_MIN);
      write_entry(1, -32'sd1000);
      write_entry(2, -32'sd1);
      write_entry(3, 32'sd0);
      write_entry(4, 32'sd0);
      write_entry(5, 32'sd5);
      write_entry(6, 32'sd77);
      write_entry(7, VALUE_MAX);
      set_entry_count(8);
      lookup_key(VALUE_MIN);
      lookup_key(VALUE_MAX);
      lookup_key(-32'sd1);
      lookup_key(32'sd0);
      lookup_key(32'sd77);
      lookup_key(VALUE_MIN + 1);
      lookup_key(32'sd1);
      lookup_key(-32'sd2000);
      lookup_key(32'sd100);
      set_entry_count(1);
      lookup_key(VALUE_MIN);
      lookup_key(32'sd0);
      set_entry_count(8);
      write_entry(5, -32'sd5000);
      lookup_key(-32'sd5000);
      lookup_key(32'sd77);
      set_entry_count(0);
      lookup_key(VALUE_MAX);
   endtask

   task automatic test_full_table();
      longint acc;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         acc = -64'sd2147483648 + longint'(i) * 64'sd4194304;
         write_entry(i, (i == TABLE_DEPTH - 1) ? VALUE_MAX : acc[VALUE_WIDTH-1:0]);
      end
      set_entry_count(TABLE_DEPTH);
      lookup_key(entry_mirror[0]);
      lookup_key(entry_mirror[TABLE_DEPTH-1]);
      lookup_key(entry_mirror[511]);
      lookup_key(entry_mirror[512]);
      lookup_key(entry_mirror[100] + 1);
      lookup_key(entry_mirror[$urandom_range(TABLE_DEPTH-1)]);
      set_entry_count((1 << CNT_W) - 1);
      lookup_key(entry_mirror[TABLE_DEPTH-1]);
      lookup_key(entry_mirror[$urandom_range(TABLE_DEPTH-1)]);
      lookup_key(entry_mirror[7] - 1);
      set_entry_count(TABLE_DEPTH + 1);
      lookup_key(entry_mirror[0]);
      lookup_key(entry_mirror[$urandom_range(TABLE_DEPTH-1)]);
   endtask

   task automatic test_backpressure();
      tx_idle_pct  = 0;
      rx_idle_pct  = 0;
      rx_hold_left = RSP_HOLD;
      for (int i = 0; i < 12; i++)
         lookup_key(entry_mirror[$urandom_range(TABLE_DEPTH-1)]);
   endtask

   task automatic test_sender_pause();
      tx_idle_pct = 0;
      rx_idle_pct = 25;
      for (int i = 0; i < 6; i++) begin
         lookup_key(entry_mirror[$urandom_range(TABLE_DEPTH-1)]);
         drain_lookups();
      end
   endtask

   task automatic test_random(input int tx_pct, input int rx_pct, input int target);
      int     stop_at;
      int     pick;
      int     cnt;
      int     span;
      int     searches;
      longint acc;
      logic signed [VALUE_WIDTH-1:0] key;
      tx_idle_pct = tx_pct;
      rx_idle_pct = rx_pct;
      stop_at     = items_sent + target;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 85)
            cnt = $urandom_range(1, 32);
         else if (pick < 95)
            cnt = $urandom_range(33, TABLE_DEPTH - 1);
         else
            case ($urandom_range(3))
               0: cnt = 0;
               1: cnt = TABLE_DEPTH;
               2: cnt = TABLE_DEPTH + $urandom_range(1, TABLE_DEPTH - 1);
               default: cnt = (1 << CNT_W) - 1;
            endcase
         set_entry_count(cnt);
         span = (cnt > TABLE_DEPTH) ? TABLE_DEPTH : cnt;
         // reload a small sorted window
         if (span > 0 && span <= 32) begin
            acc = ($urandom_range(9) == 0) ? -64'sd2147483648
                                           : longint'($signed(32'($urandom)));
            for (int i = 0; i < span; i++) begin
               if (i == span - 1 && $urandom_range(9) == 0)
                  acc = 64'sd2147483647;
               write_entry(i, acc[VALUE_WIDTH-1:0]);
               if ($urandom_range(3) != 0)
                  acc += longint'(1) << $urandom_range(24);
               if (acc > 64'sd2147483647)
                  acc = 64'sd2147483647;
            end
         end
         searches = $urandom_range(4, 16);
         for (int s = 0; s < searches; s++) begin
            pick = $urandom_range(99);
            key  = (span > 0) ? entry_mirror[$urandom_range(span - 1)] : $urandom;
            if (pick < 60)
               lookup_key(key);
            else if (pick < 75)
               lookup_key($urandom_range(1) ? key + 1 : key - 1);
            else if (pick < 88)
               lookup_key($urandom);
            else
               write_entry($urandom_range(TABLE_DEPTH - 1), $urandom);
         end
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_action      = ACT_WRITE;
      req_entry_index = '0;
      req_entry_value = '0;
      req_search_key  = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_entry_count = '0;
      count_mirror    = '0;
      mismatch_count  = 0;
      items_sent      = 0;
      cycle_count     = 0;
      tx_idle_pct     = 0;
      rx_idle_pct     = 0;
      rx_hold_left    = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_full_table();
      test_backpressure();
      test_sender_pause();
      test_random(25, 64, 100);
      test_random(64, 25, 100);
      test_random(0, 0, 100);

      drain_lookups();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_lookups.size() != 0)
         mismatch_count++;
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
